// ===== rtl/hbn_pkg.sv =====
// Shared types, register indexes and constants for the HOG block normalizer.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package hbn_pkg;

  localparam int MAX_BLOCK_ELEMS = 64;
  localparam int ADDR_BITS       = 6;
  localparam int COUNT_BITS      = 7;
  localparam int VALUE_BITS      = 24;
  localparam int ACC_BITS        = 54;
  localparam int DEN_BITS        = 55;
  localparam int NUM_BITS        = 44;
  localparam int SQRT_BITS       = 64;
  localparam int ROOT_BITS       = 32;
  localparam int CLIP_BITS       = 17;
  localparam int SQ_BITS         = 2 * CLIP_BITS;
  localparam int D2_BITS         = 41;
  localparam int CFG_IDX_BITS    = 4;
  localparam int CFG_DATA_BITS   = 17;

  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
  localparam logic [NUM_BITS-1:0] Q_ONE   = NUM_BITS'(65536);

  // normalization modes
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_L1     = 3'd1;
  localparam logic [2:0] MODE_L1SQRT = 3'd2;
  localparam logic [2:0] MODE_L2     = 3'd3;
  localparam logic [2:0] MODE_L2HYS  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_NORM_MODE    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_LENGTH = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPSILON      = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEVEL   = 4'd3;

  typedef struct packed {
    logic [23:0] bin_value;
    logic        block_end;
  } in_item_t;

  typedef struct packed {
    logic [23:0] norm_value;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  norm_mode;
    logic [6:0]  block_length;
    logic [15:0] epsilon;
    logic [16:0] clip_level;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic in_take;
    logic setup;
    logic root_load;
    logic fetch;
    logic sel_clip;
    logic div_start;
    logic div_load;
    logic sq_start;
    logic sq_root_den;
    logic sq_load;
    logic clip;
    logic hys_mul;
    logic hys_add;
    logic d2_load;
    logic out_next;
    logic blk_clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_done;
    logic den_zero;
    logic last_idx;
    logic div_done;
    logic sq_done;
  } status_t;

endpackage

// ===== rtl/hbn_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on hbn_pkg for widths.
module hbn_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hbn_pkg::NUM_BITS-1:0]  num,
  input  logic [hbn_pkg::DEN_BITS-1:0]  den,
  output logic                          done,
  output logic [hbn_pkg::NUM_BITS-1:0]  quo
);

  logic                         busy;
  logic [5:0]                   cnt;
  logic [hbn_pkg::DEN_BITS-1:0] rem;
  logic [hbn_pkg::DEN_BITS-1:0] dsr;
  logic [hbn_pkg::DEN_BITS:0]   rem_sh;
  logic                         ge;

  assign rem_sh = {rem, quo[hbn_pkg::NUM_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= den;
        quo  <= num;
      end else if (busy) begin
        rem <= ge ? hbn_pkg::DEN_BITS'(rem_sh - {1'b0, dsr})
                  : rem_sh[hbn_pkg::DEN_BITS-1:0];
        quo <= {quo[hbn_pkg::NUM_BITS-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(hbn_pkg::NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/hbn_sqrt.sv =====
// Integer floor square root, one result bit per cycle.
// Depends on hbn_pkg for widths.
module hbn_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [hbn_pkg::SQRT_BITS-1:0]  x,
  output logic                           done,
  output logic [hbn_pkg::ROOT_BITS-1:0]  root
);

  logic                          busy;
  logic [4:0]                    cnt;
  logic [hbn_pkg::SQRT_BITS-1:0] rem;
  logic [hbn_pkg::SQRT_BITS-1:0] res;
  logic [hbn_pkg::SQRT_BITS-1:0] bitv;
  logic [hbn_pkg::SQRT_BITS-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[hbn_pkg::ROOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= x;
        res  <= '0;
        bitv <= hbn_pkg::SQRT_BITS'(1) << (hbn_pkg::SQRT_BITS - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/hbn_datapath.sv =====
// Datapath: value and clipped-value memories, accumulators, working value,
// shared divider and root units. Depends on hbn_pkg, hbn_div, hbn_sqrt.
module hbn_datapath (
  input  logic              clk,
  input  logic              rst,
  input  hbn_pkg::cfg_t     cfg,
  input  hbn_pkg::cmd_t     cmd,
  input  hbn_pkg::in_item_t in_data,
  output hbn_pkg::status_t  status,
  output logic [23:0]       cur_value
);

  logic [23:0]                    store_mem [hbn_pkg::MAX_BLOCK_ELEMS];
  logic [hbn_pkg::CLIP_BITS-1:0]  clip_mem  [hbn_pkg::MAX_BLOCK_ELEMS];
  logic [23:0]                    store_rd;
  logic [hbn_pkg::CLIP_BITS-1:0]  clip_rd;

  logic [hbn_pkg::COUNT_BITS-1:0] fill;
  logic [hbn_pkg::COUNT_BITS-1:0] fill_plus;
  logic [hbn_pkg::COUNT_BITS-1:0] len_eff;
  logic [hbn_pkg::COUNT_BITS-1:0] idx;
  logic [hbn_pkg::ACC_BITS-1:0]   acc;
  logic [hbn_pkg::ACC_BITS:0]     acc_sum;
  logic [47:0]                    pend_term;
  logic                           pend_valid;
  logic                           squares;
  logic [hbn_pkg::DEN_BITS-1:0]   den;
  logic [hbn_pkg::D2_BITS-1:0]    d2;
  logic [hbn_pkg::SQ_BITS-1:0]    prod;
  logic [23:0]                    cur;
  logic                           l2_shift;

  logic [hbn_pkg::NUM_BITS-1:0]   div_num;
  logic [hbn_pkg::NUM_BITS-1:0]   div_quo;
  logic                           div_done;
  logic [hbn_pkg::SQRT_BITS-1:0]  sq_x;
  logic [hbn_pkg::ROOT_BITS-1:0]  sq_root;
  logic                           sq_done;

  // effective block length, saturated into 2..64
  always_comb begin
    if (cfg.block_length < 7'd2) begin
      len_eff = 7'd2;
    end else if (cfg.block_length > 7'(hbn_pkg::MAX_BLOCK_ELEMS)) begin
      len_eff = 7'(hbn_pkg::MAX_BLOCK_ELEMS);
    end else begin
      len_eff = cfg.block_length;
    end
  end

  assign fill_plus = fill + 7'd1;
  assign squares   = (cfg.norm_mode == hbn_pkg::MODE_L2) ||
                     (cfg.norm_mode == hbn_pkg::MODE_L2HYS);
  assign l2_shift  = squares;
  assign acc_sum   = {1'b0, acc} + {7'd0, pend_term};

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      store_mem[fill[hbn_pkg::ADDR_BITS-1:0]] <= in_data.bin_value;
    end
    if (cmd.hys_mul) begin
      clip_mem[idx[hbn_pkg::ADDR_BITS-1:0]] <= cur[hbn_pkg::CLIP_BITS-1:0];
    end
    store_rd <= store_mem[idx[hbn_pkg::ADDR_BITS-1:0]];
    clip_rd  <= clip_mem[idx[hbn_pkg::ADDR_BITS-1:0]];
  end

  // load side: fill count and accumulator (term registered, added next cycle)
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      acc        <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.in_take;
      if (pend_valid) begin
        acc <= (acc_sum > {1'b0, hbn_pkg::ACC_MAX}) ? hbn_pkg::ACC_MAX
                                                     : acc_sum[hbn_pkg::ACC_BITS-1:0];
      end
      if (cmd.in_take) begin
        fill <= fill_plus;
      end
      if (cmd.blk_clear) begin
        fill <= '0;
        acc  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      pend_term <= squares ? in_data.bin_value * in_data.bin_value
                           : {24'd0, in_data.bin_value};
    end
  end

  // element index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.setup || cmd.d2_load) begin
      idx <= '0;
    end else if (cmd.hys_add || cmd.out_next) begin
      idx <= idx + 7'd1;
    end
  end

  // denominators and working value
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      den <= hbn_pkg::DEN_BITS'(acc) + hbn_pkg::DEN_BITS'(cfg.epsilon);
      d2  <= hbn_pkg::D2_BITS'(cfg.epsilon);
    end
    if (cmd.root_load) begin
      den <= hbn_pkg::DEN_BITS'(sq_root);
    end
    if (cmd.d2_load) begin
      den <= hbn_pkg::DEN_BITS'(d2);
    end
    if (cmd.hys_mul) begin
      prod <= cur[hbn_pkg::CLIP_BITS-1:0] * cur[hbn_pkg::CLIP_BITS-1:0];
    end
    if (cmd.hys_add) begin
      d2 <= d2 + hbn_pkg::D2_BITS'(prod);
    end
    if (cmd.fetch) begin
      cur <= cmd.sel_clip ? 24'(clip_rd) : store_rd;
    end
    if (cmd.div_load) begin
      cur <= (div_quo > hbn_pkg::Q_ONE) ? 24'(hbn_pkg::Q_ONE) : div_quo[23:0];
    end
    if (cmd.sq_load) begin
      cur <= sq_root[23:0];
    end
    if (cmd.clip) begin
      if (cur > 24'(cfg.clip_level)) begin
        cur <= 24'(cfg.clip_level);
      end
    end
  end

  assign div_num = l2_shift ? {cur, 20'd0} : {4'd0, cur, 16'd0};
  assign sq_x    = cmd.sq_root_den ? {1'b0, den, 8'd0} : {24'd0, cur, 16'd0};

  hbn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  hbn_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign status.blk_done = cmd.in_take && (in_data.block_end || (fill_plus >= len_eff));
  assign status.den_zero = (den == '0);
  assign status.last_idx = (idx == fill - 7'd1);
  assign status.div_done = div_done;
  assign status.sq_done  = sq_done;
  assign cur_value       = cur;

endmodule

// ===== rtl/hbn_ctrl.sv =====
// Controller state machine: sequences loading, root, hysteresis and output
// passes. Depends on hbn_pkg.
module hbn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  hbn_pkg::cfg_t    cfg,
  input  hbn_pkg::status_t status,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output hbn_pkg::cmd_t    cmd
);

  typedef enum logic [15:0] {
    S_LOAD    = 16'h0001,
    S_ACC     = 16'h0002,
    S_SETUP   = 16'h0004,
    S_ROOT_GO = 16'h0008,
    S_ROOT_W  = 16'h0010,
    S_RD      = 16'h0020,
    S_FETCH   = 16'h0040,
    S_DIV_GO  = 16'h0080,
    S_DIV_W   = 16'h0100,
    S_SQ_GO   = 16'h0200,
    S_SQ_W    = 16'h0400,
    S_CLIP    = 16'h0800,
    S_HMUL    = 16'h1000,
    S_HADD    = 16'h2000,
    S_D2      = 16'h4000,
    S_OUT     = 16'h8000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_div;
  logic   pass1;
  logic   mode_none;
  logic   mode_sqrt;
  logic   mode_l2;
  logic   out_fire;

  assign mode_sqrt = (cfg.norm_mode == hbn_pkg::MODE_L1SQRT);
  assign mode_l2   = (cfg.norm_mode == hbn_pkg::MODE_L2) ||
                     (cfg.norm_mode == hbn_pkg::MODE_L2HYS);
  assign mode_none = !((cfg.norm_mode == hbn_pkg::MODE_L1) || mode_sqrt || mode_l2);

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT);
  assign out_fire  = out_valid && out_ready;

  // where an element goes once its quotient (or pass-through) is in place
  always_comb begin
    if (mode_sqrt) begin
      after_div = S_SQ_GO;
    end else if (pass1) begin
      after_div = S_CLIP;
    end else begin
      after_div = S_OUT;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:    if (status.blk_done) state_next = S_ACC;
      S_ACC:     state_next = S_SETUP;
      S_SETUP:   state_next = mode_l2 ? S_ROOT_GO : S_RD;
      S_ROOT_GO: state_next = S_ROOT_W;
      S_ROOT_W:  if (status.sq_done) state_next = S_RD;
      S_RD:      state_next = S_FETCH;
      S_FETCH: begin
        if (mode_none) begin
          state_next = S_OUT;
        end else if (status.den_zero) begin
          state_next = after_div;
        end else begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO:  state_next = S_DIV_W;
      S_DIV_W:   if (status.div_done) state_next = after_div;
      S_SQ_GO:   state_next = S_SQ_W;
      S_SQ_W:    if (status.sq_done) state_next = S_OUT;
      S_CLIP:    state_next = S_HMUL;
      S_HMUL:    state_next = S_HADD;
      S_HADD:    state_next = status.last_idx ? S_D2 : S_RD;
      S_D2:      state_next = S_ROOT_GO;
      S_OUT: begin
        if (out_fire) begin
          state_next = status.last_idx ? S_LOAD : S_RD;
        end
      end
      default:   state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      pass1 <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SETUP) begin
        pass1 <= (cfg.norm_mode == hbn_pkg::MODE_L2HYS);
      end else if (state == S_D2) begin
        pass1 <= 1'b0;
      end
    end
  end

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.in_take     = in_valid && in_ready;
    cmd.setup       = (state == S_SETUP);
    cmd.root_load   = (state == S_ROOT_W) && status.sq_done;
    cmd.fetch       = (state == S_FETCH);
    cmd.sel_clip    = (cfg.norm_mode == hbn_pkg::MODE_L2HYS) && !pass1;
    cmd.div_start   = (state == S_DIV_GO);
    cmd.div_load    = (state == S_DIV_W) && status.div_done;
    cmd.sq_start    = (state == S_SQ_GO) || (state == S_ROOT_GO);
    cmd.sq_root_den = (state == S_ROOT_GO);
    cmd.sq_load     = (state == S_SQ_W) && status.sq_done;
    cmd.clip        = (state == S_CLIP);
    cmd.hys_mul     = (state == S_HMUL);
    cmd.hys_add     = (state == S_HADD);
    cmd.d2_load     = (state == S_D2);
    cmd.out_next    = out_fire;
    cmd.blk_clear   = out_fire && status.last_idx;
  end

endmodule

// ===== rtl/hog_block_normalizer_top.sv =====
// Values load one per cycle while in the load state; no new value is taken
//   until the block is out. Per element: none passes through, L1 divides,
//   L1-sqrt divides then roots, L2 divides after a block root, and L2-hys
//   runs two passes, each after a block root. Divider and root are bit-serial.
// Reset (synchronous rst) empties the block and restores register defaults.
// Top level: configuration registers, controller and datapath.
// Depends on hbn_pkg, hbn_ctrl, hbn_datapath.
module hog_block_normalizer_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  hbn_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output hbn_pkg::out_item_t                    out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hbn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [hbn_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  hbn_pkg::cfg_t    cfg;
  hbn_pkg::cmd_t    cmd;
  hbn_pkg::status_t status;
  logic [23:0]      cur_value;

  assign cfg_ready = 1'b1;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.norm_mode    <= hbn_pkg::MODE_NONE;
      cfg.block_length <= 7'd36;
      cfg.epsilon      <= 16'd0;
      cfg.clip_level   <= 17'd13107;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbn_pkg::REG_NORM_MODE:    cfg.norm_mode    <= cfg_data[2:0];
        hbn_pkg::REG_BLOCK_LENGTH: cfg.block_length <= cfg_data[6:0];
        hbn_pkg::REG_EPSILON:      cfg.epsilon      <= cfg_data[15:0];
        hbn_pkg::REG_CLIP_LEVEL:   cfg.clip_level   <= cfg_data;
        default: ;
      endcase
    end
  end

  hbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .status    (status),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hbn_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .cur_value (cur_value)
  );

  assign out_data.norm_value = cur_value;
  assign out_data.last_out   = status.last_idx;

endmodule

// ===== test/tb_hog_block_normalizer_top.sv =====
// Self-checking testbench for hog_block_normalizer_top: random and directed HOG
// blocks over every normalization mode, checked against an in-bench predictor.
// Depends on hbn_pkg and the RTL of hog_block_normalizer_top.
module tb_hog_block_normalizer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hbn_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int SETTLE_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  hog_block_normalizer_top DUT (.*);

  always #5 clk = ~clk;

  // shadow configuration and block state
  logic [2:0]  mode_q;
  logic [6:0]  blen_q;
  logic [15:0] eps_q;
  logic [16:0] clip_q;
  logic [63:0] bin_store [MAX_BLOCK_ELEMS];
  int          fill_q;
  logic [63:0] sum_q;

  in_item_t  bin_queue [$];
  out_item_t norm_queue [$];
  int errors = 0, blocks_done = 0, bins_sent = 0, norms_seen = 0;
  int src_idle = 0, sink_stall = 0;

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] cap_unit(logic [63:0] q);
    return (q > 64'd65536) ? 64'd65536 : q;
  endfunction

  // value over root of a sum of squares, Q1.16, passthrough on zero root
  function automatic logic [63:0] l2_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] r;
    r = floor_root(den << 8);
    if (r == 0) return num;
    return cap_unit((num << 20) / r);
  endfunction

  // absorb one bin; emit the whole normalized block when it completes
  task automatic absorb_bin(in_item_t it);
    logic [63:0] v, d, d2, r, s;
    logic [63:0] clipped [MAX_BLOCK_ELEMS];
    int len;
    out_item_t o;
    v = 64'(it.bin_value);
    len = (blen_q < 2) ? 2 : (blen_q > MAX_BLOCK_ELEMS) ? MAX_BLOCK_ELEMS : int'(blen_q);
    if (fill_q < MAX_BLOCK_ELEMS) begin
      bin_store[fill_q] = v;
      fill_q++;
      s = sum_q + ((mode_q == MODE_L2 || mode_q == MODE_L2HYS) ? v * v : v);
      sum_q = (s > 64'(ACC_MAX)) ? 64'(ACC_MAX) : s;
    end
    if (!it.block_end && fill_q < len) return;
    d = sum_q + 64'(eps_q);
    d2 = 64'(eps_q);
    if (mode_q == MODE_L2HYS) begin
      for (int i = 0; i < fill_q; i++) begin
        clipped[i] = l2_ratio(bin_store[i], d);
        if (clipped[i] > 64'(clip_q)) clipped[i] = 64'(clip_q);
        d2 += clipped[i] * clipped[i];
      end
    end
    for (int i = 0; i < fill_q; i++) begin
      case (mode_q)
        MODE_L1: r = (d == 0) ? bin_store[i] : cap_unit((bin_store[i] << 16) / d);
        MODE_L1SQRT: begin
          r = (d == 0) ? bin_store[i] : cap_unit((bin_store[i] << 16) / d);
          r = floor_root(r << 16);
        end
        MODE_L2: r = l2_ratio(bin_store[i], d);
        MODE_L2HYS: r = l2_ratio(clipped[i], d2);
        default: r = bin_store[i];
      endcase
      o.norm_value = r[23:0];
      o.last_out = (i + 1 == fill_q);
      norm_queue.push_back(o);
    end
    fill_q = 0;
    sum_q = 0;
    blocks_done++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, norms_seen);
    errors++;
  endtask

  // input driver: payload held until the transfer completes
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_bin(in_data);
        void'(bin_queue.pop_front());
        bins_sent++;
      end
      if (!in_valid || in_ready) begin
        if (bin_queue.size() > 0 && $urandom_range(99) >= src_idle) begin
          in_valid <= 1'b1;
          in_data <= bin_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        norms_seen++;
        if (norm_queue.size() == 0) begin
          report_mismatch("unexpected result, norm_value", 32'(out_data.norm_value), 32'd0);
        end else begin
          if (out_data.norm_value !== norm_queue[0].norm_value)
            report_mismatch("norm_value", 32'(out_data.norm_value),
                            32'(norm_queue[0].norm_value));
          if (out_data.last_out !== norm_queue[0].last_out)
            report_mismatch("last_out", 32'(out_data.last_out), 32'(norm_queue[0].last_out));
          void'(norm_queue.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", norm_queue.size());
      $display("** hog_block_normalizer_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_NORM_MODE:    mode_q = val[2:0];
      REG_BLOCK_LENGTH: blen_q = val[6:0];
      REG_EPSILON:      eps_q = val[15:0];
      REG_CLIP_LEVEL:   clip_q = val[16:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // wait until every bin is taken and every result is back, then let it settle
  task automatic drain();
    while (bin_queue.size() != 0 || in_valid || norm_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_bin();
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(255));
      3: return 24'($urandom_range(65535));
      default: return 24'($urandom);
    endcase
  endfunction

  // queue one block; sometimes cut short by the end flag
  task automatic queue_block(int len);
    int n;
    in_item_t it;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, len) : len;
    for (int i = 0; i < n; i++) begin
      it.bin_value = pick_bin();
      it.block_end = (i == n - 1) ? ((n < len) ? 1'b1 : 1'($urandom_range(1))) : 1'b0;
      bin_queue.push_back(it);
    end
  endtask

  function automatic in_item_t mk(logic [23:0] v, logic e);
    in_item_t it;
    it.bin_value = v;
    it.block_end = e;
    return it;
  endfunction

  initial begin
    int len, phase;
    logic [CFG_DATA_BITS-1:0] lens [8];
    lens = '{0, 1, 2, 3, 5, 8, 64, 127};
    mode_q = MODE_NONE;
    blen_q = 7'd36;
    eps_q = '0;
    clip_q = 17'd13107;
    fill_q = 0;
    sum_q = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes under every mode, length 2 blocks
    write_reg(REG_BLOCK_LENGTH, 17'd2);
    for (int m = 0; m < 5; m++) begin
      write_reg(REG_NORM_MODE, 17'(m));
      bin_queue.push_back(mk(24'hFFFFFF, 1'b0));
      bin_queue.push_back(mk(24'h000001, 1'b0));
      drain();
    end
    // zero denominator: all-zero block with no epsilon
    write_reg(REG_NORM_MODE, 17'(MODE_L1));
    bin_queue.push_back(mk(24'h0, 1'b0));
    bin_queue.push_back(mk(24'h0, 1'b1));
    drain();
    // L2-hys with full clip ceiling and max epsilon, unknown mode, bad index
    write_reg(REG_NORM_MODE, 17'(MODE_L2HYS));
    write_reg(REG_CLIP_LEVEL, 17'd65536);
    write_reg(REG_EPSILON, 17'd65535);
    bin_queue.push_back(mk(24'd300, 1'b0));
    bin_queue.push_back(mk(24'd7, 1'b1));
    drain();
    write_reg(REG_NORM_MODE, 17'd6);
    write_reg(4'd9, 17'h1FFFF);
    bin_queue.push_back(mk(24'hABCDEF, 1'b0));
    bin_queue.push_back(mk(24'h123456, 1'b0));
    drain();
    // mode change inside a held block; single-bin block closed by the end flag
    write_reg(REG_BLOCK_LENGTH, 17'd36);
    write_reg(REG_NORM_MODE, 17'(MODE_L1));
    bin_queue.push_back(mk(24'd5000, 1'b0));
    bin_queue.push_back(mk(24'hFFFFFF, 1'b0));
    drain();
    write_reg(REG_NORM_MODE, 17'(MODE_L2));
    bin_queue.push_back(mk(24'd77, 1'b1));
    bin_queue.push_back(mk(24'd9, 1'b1));
    drain();

    // random phases over configurations and idling patterns
    phase = 0;
    while (bins_sent < 320) begin
      case (phase % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 66; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 66; end
        default: begin src_idle = 7; sink_stall = 7; end
      endcase
      write_reg(REG_NORM_MODE, 17'(phase % 8));
      write_reg(REG_BLOCK_LENGTH, (phase % 5 == 4) ? lens[$urandom_range(6, 7)]
                                                   : lens[$urandom_range(5)]);
      case ($urandom_range(2))
        0: write_reg(REG_EPSILON, 17'd0);
        1: write_reg(REG_EPSILON, 17'd65535);
        default: write_reg(REG_EPSILON, 17'($urandom_range(65535)));
      endcase
      case ($urandom_range(3))
        0: write_reg(REG_CLIP_LEVEL, 17'd0);
        1: write_reg(REG_CLIP_LEVEL, 17'd65536);
        2: write_reg(REG_CLIP_LEVEL, 17'd13107);
        default: write_reg(REG_CLIP_LEVEL, 17'($urandom));
      endcase
      len = (blen_q < 2) ? 2 : (blen_q > MAX_BLOCK_ELEMS) ? MAX_BLOCK_ELEMS : int'(blen_q);
      for (int b = 0; b < ((len > 8) ? 1 : 5); b++) queue_block(len);
      drain();
      phase++;
    end

    src_idle = 0;
    sink_stall = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d bins in %0d blocks, %0d results checked, modes 0-7, %0d phases",
             bins_sent, blocks_done, norms_seen, phase);
    if (errors == 0 && norm_queue.size() == 0) begin
      $display("** hog_block_normalizer_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, norm_queue.size());
      $display("** hog_block_normalizer_top: FAILED **");
    end
    $finish;
  end

endmodule
